### design/assert_macros.svh
// assertion macros for the design modules, used by rtf_ctrl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

### design/rtf_pkg.sv
// types and constants for the ranked table block
// no dependencies
package rtf_pkg;
  localparam int unsigned NameW  = 64;
  localparam int unsigned AgeW   = 8;
  localparam int unsigned WorthW = 21;
  localparam int unsigned RecW   = NameW + AgeW + WorthW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LSCAN,
    ST_LSHIFT,
    ST_QSCAN,
    ST_QEMIT,
    ST_NONE
  } state_e;

  typedef struct packed {
    logic [NameW-1:0]  name;
    logic [AgeW-1:0]   age;
    logic [WorthW-1:0] worth;
  } rec_t;

  typedef struct packed {
    logic capture;
    logic clr_idx;
    logic inc_idx;
    logic dec_idx;
    logic set_idx_last;
    logic rd_en;
    logic rd_prev;
    logic wr_prev;
    logic wr_new;
    logic inc_fill;
    logic inc_cnt;
  } cmd_t;

  typedef struct packed {
    logic idx_at_fill;
    logic idx_le_pos;
    logic ahead;
    logic match;
    logic cnt_hit;
    logic full;
    logic is_query;
  } sts_t;

  function automatic logic ranks_before(rec_t a, rec_t b);
    logic r;
    if ($signed(a.worth) != $signed(b.worth)) r = $signed(a.worth) > $signed(b.worth);
    else if (a.age != b.age) r = a.age < b.age;
    else r = a.name < b.name;
    return r;
  endfunction
endpackage

### design/rtf_ram.sv
// generic single-port-write, one-read ram with registered read
// no dependencies
module rtf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end
  assign rdata_o = rdata_q;
endmodule

### design/rtf_ctrl.sv
// controller state machine for the ranked table
// depends on rtf_pkg and assert_macros.svh
`include "assert_macros.svh"
module rtf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_load_o,
  output logic              out_found_o,
  output logic              out_last_o,
  input  logic              out_free_i,
  input  rtf_pkg::sts_t     sts_i,
  output rtf_pkg::cmd_t     cmd_o
);
  rtf_pkg::state_e state_q, state_d;
  logic            rd_ok_q, rd_ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtf_pkg::ST_IDLE;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  // table read data is registered: rd_ok marks the read data as current in the cycle after the read
  always_comb begin
    state_d     = state_q;
    rd_ok_d     = 1'b0;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_load_o  = 1'b0;
    out_found_o = 1'b0;
    out_last_o  = 1'b0;
    case (state_q)
      rtf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d = rtf_pkg::ST_LSCAN;
        end
      end
      rtf_pkg::ST_LSCAN: begin
        if (sts_i.is_query) begin
          state_d = rtf_pkg::ST_QSCAN;
        end else if (rd_ok_q && sts_i.ahead) begin
          cmd_o.set_idx_last = 1'b1;
          state_d = rtf_pkg::ST_LSHIFT;
        end else if (!rd_ok_q && !sts_i.idx_at_fill) begin
          cmd_o.rd_en = 1'b1;
          rd_ok_d = 1'b1;
        end else if (rd_ok_q) begin
          cmd_o.inc_idx = 1'b1;
        end else if (!sts_i.full) begin
          cmd_o.set_idx_last = 1'b1;
          state_d = rtf_pkg::ST_LSHIFT;
        end else begin
          state_d = rtf_pkg::ST_IDLE;
        end
      end
      rtf_pkg::ST_LSHIFT: begin
        if (sts_i.idx_le_pos) begin
          cmd_o.wr_new = 1'b1;
          if (!sts_i.full) cmd_o.inc_fill = 1'b1;
          state_d = rtf_pkg::ST_IDLE;
        end else if (!rd_ok_q) begin
          cmd_o.rd_prev = 1'b1;
          rd_ok_d = 1'b1;
        end else begin
          cmd_o.wr_prev = 1'b1;
          cmd_o.dec_idx = 1'b1;
        end
      end
      rtf_pkg::ST_QSCAN: begin
        if (rd_ok_q && sts_i.match) begin
          state_d = rtf_pkg::ST_QEMIT;
        end else if (sts_i.cnt_hit || (!rd_ok_q && sts_i.idx_at_fill)) begin
          state_d = rtf_pkg::ST_NONE;
        end else if (rd_ok_q) begin
          cmd_o.inc_idx = 1'b1;
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_ok_d = 1'b1;
        end
      end
      rtf_pkg::ST_QEMIT: begin
        rd_ok_d = 1'b1;
        if (out_free_i) begin
          out_load_o  = 1'b1;
          out_found_o = 1'b1;
          cmd_o.inc_cnt = 1'b1;
          cmd_o.inc_idx = 1'b1;
          rd_ok_d = 1'b0;
          state_d = rtf_pkg::ST_QSCAN;
        end
      end
      rtf_pkg::ST_NONE: begin
        // closing word: marks last on the held record or sends a no-match word
        if (out_free_i) begin
          out_load_o = 1'b1;
          out_last_o = 1'b1;
          state_d = rtf_pkg::ST_IDLE;
        end
      end
      default: state_d = rtf_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == rtf_pkg::ST_IDLE)
  `ASSERT_IMPL(a_emit_free, clk_i, rst_ni, out_load_o, out_free_i)
  `ASSERT_IMPL(a_no_wr_query, clk_i, rst_ni, cmd_o.wr_new || cmd_o.wr_prev,
               !sts_i.is_query)
  `ASSERT_NEXT(a_rd_follow, clk_i, rst_ni, cmd_o.rd_en || cmd_o.rd_prev, rd_ok_q)
endmodule

### design/rtf_dp.sv
// datapath: table memory, index counters, compare logic and output buffer
// depends on rtf_pkg and rtf_ram
module rtf_dp #(
  parameter int unsigned Capacity  = 256,
  parameter int unsigned MaxReturn = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [116:0]            in_data_i,
  input  logic                    out_load_i,
  input  logic                    out_found_i,
  input  logic                    out_last_i,
  output logic                    out_free_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [95:0]             out_data_o,
  output logic                    out_last_o,
  input  rtf_pkg::cmd_t           cmd_i,
  output rtf_pkg::sts_t           sts_o
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned FW = $clog2(Capacity + 1);

  rtf_pkg::rec_t   rec_q, rd_rec;
  logic            mode_q;
  logic [6:0]      lim_q;
  logic [7:0]      lo_q, hi_q;
  logic [FW-1:0]   fill_q, idx_q, pos_q;
  logic [6:0]      cnt_q;
  logic            ov_q, hold_q, hfound_q;
  rtf_pkg::rec_t   hrec_q;
  logic [95:0]     obuf_q;
  logic            olast_q;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  rtf_pkg::rec_t   wdata;
  logic [6:0]      lim_c;

  assign we    = cmd_i.wr_new || cmd_i.wr_prev;
  assign waddr = cmd_i.wr_new ? pos_q[AW-1:0] : idx_q[AW-1:0];
  assign wdata = cmd_i.wr_new ? rec_q : rd_rec;
  assign raddr = cmd_i.rd_prev ? AW'(idx_q - FW'(1)) : idx_q[AW-1:0];

  rtf_ram #(.Width(rtf_pkg::RecW), .Depth(Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_rec)
  );

  assign lim_c = (lim_q > 7'(MaxReturn)) ? 7'(MaxReturn) : lim_q;

  always_comb begin
    sts_o.idx_at_fill = (idx_q == fill_q) || (idx_q == FW'(Capacity));
    sts_o.idx_le_pos  = idx_q <= pos_q;
    sts_o.ahead       = rtf_pkg::ranks_before(rec_q, rd_rec);
    sts_o.match       = (rd_rec.age >= lo_q) && (rd_rec.age <= hi_q);
    sts_o.cnt_hit     = (cnt_q >= lim_c) || (lo_q > hi_q);
    sts_o.full        = fill_q == FW'(Capacity);
    sts_o.is_query    = mode_q;
  end

  // in the shift state pos holds the insert place and idx walks down from the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      hold_q  <= 1'b0;
      idx_q   <= '0;
      pos_q   <= '0;
    end else begin
      if (cmd_i.capture) begin
        cnt_q  <= '0;
        hold_q <= 1'b0;
      end
      if (cmd_i.clr_idx) idx_q <= '0;
      if (cmd_i.inc_idx) idx_q <= idx_q + FW'(1);
      if (cmd_i.dec_idx) idx_q <= idx_q - FW'(1);
      if (cmd_i.set_idx_last) begin
        pos_q <= idx_q;
        idx_q <= sts_o.full ? FW'(Capacity - 1) : fill_q;
      end else if (cmd_i.capture) begin
        pos_q <= '0;
      end
      if (cmd_i.inc_fill) fill_q <= fill_q + FW'(1);
      if (cmd_i.inc_cnt) cnt_q <= cnt_q + 7'd1;
      if (out_load_i) begin
        hold_q <= out_found_i;
      end
      ov_q <= (ov_q && !out_ready_i) || (out_load_i && (hold_q || out_last_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= in_data_i[0];
      rec_q.name  <= in_data_i[64:1];
      rec_q.age   <= in_data_i[72:65];
      rec_q.worth <= in_data_i[93:73];
      lim_q <= in_data_i[100:94];
      lo_q  <= in_data_i[108:101];
      hi_q  <= in_data_i[116:109];
    end
    if (out_load_i && out_found_i) begin
      hrec_q   <= rd_rec;
      hfound_q <= 1'b1;
    end
    if (out_load_i && (hold_q || out_last_i)) begin
      if (hold_q) begin
        obuf_q  <= {2'b0, hrec_q.worth, hrec_q.age, hrec_q.name, hfound_q};
        olast_q <= out_last_i;
      end else begin
        obuf_q  <= '0;
        olast_q <= 1'b1;
      end
    end
  end

  assign out_free_o  = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = obuf_q;
  assign out_last_o  = olast_q;
endmodule

### design/ranked_table_filtered_topk.sv
// ranked table with age-filtered top-k query, top level
// depends on rtf_pkg, rtf_ctrl, rtf_dp
// load: compares the record with each entry in turn, then moves the later entries down and writes it in place
// query: scans the entries in rank order and returns each match, waiting under output stalls
// one item at a time; rate is set by the single read port of the table memory
// reset clears the fill count and control; table contents stay undefined until written
module ranked_table_filtered_topk #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned MAX_RETURN = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // mode, person_name, person_age, person_worth, max_count, age_low, age_high
  input  logic [119:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // found, out_name, out_age, out_worth
  output logic [95:0]  m_tdata_o,
  output logic         m_tlast_o
);
  rtf_pkg::cmd_t cmd;
  rtf_pkg::sts_t sts;
  logic          oload, ofound, olast, ofree;

  rtf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_tvalid_i), .in_ready_o (s_tready_o),
    .out_load_o (oload), .out_found_o (ofound), .out_last_o (olast),
    .out_free_i (ofree), .sts_i (sts), .cmd_o (cmd)
  );

  rtf_dp #(.Capacity(CAPACITY), .MaxReturn(MAX_RETURN)) u_dp (
    .clk_i, .rst_ni,
    .in_data_i (s_tdata_i[116:0]), .out_load_i (oload), .out_found_i (ofound),
    .out_last_i (olast), .out_free_o (ofree), .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i), .out_data_o (m_tdata_o), .out_last_o (m_tlast_o),
    .cmd_i (cmd), .sts_o (sts)
  );
endmodule
